// ----- rtl/accc_pkg.sv -----
package accc_pkg;

    // Chain geometry
    localparam int NUM_SLOTS = 4;
    localparam int MASK_BITS = 4;
    localparam int ROM_BYTES = 128;

    // Config space decode
    localparam logic [31:0] CONFIG_BASE    = 32'd15204352;
    localparam logic [15:0] BASE_HI_OFFSET = 16'd72;
    localparam logic [15:0] Z3_HI_OFFSET   = 16'd68;
    localparam logic [15:0] SHUTUP_OFFSET  = 16'd76;
    localparam logic [15:0] SHUTUP_ALT     = SHUTUP_OFFSET + 16'd2;

    // Derived widths
    localparam int POS_W     = $clog2(NUM_SLOTS + 1);
    localparam int RAM_DEPTH = NUM_SLOTS * ROM_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [7:0] QUIET_BYTE = 8'hFF;

    // Action codes
    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_WRITE   = 2'd2;
    localparam logic [1:0] ACT_LOAD    = 2'd3;

    // Config register indexes
    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_ZORRO3  = 2'd1;
    localparam logic [1:0] CFG_HAS_ROM = 2'd2;

    // Per-slot attribute bits held in each cell
    typedef struct packed {
        logic en;
        logic z3;
        logic rom;
    } slot_bits_t;

    // Token movement along the chain
    typedef struct packed {
        logic restart;
        logic advance;
    } tok_ctl_t;

    // Config register write strobes, broadcast to every cell
    typedef struct packed {
        logic we_en;
        logic we_z3;
        logic we_rom;
    } cfg_ctl_t;

    function automatic logic [RAM_AW-1:0] rom_addr(input logic [31:0] slot,
                                                   input logic [31:0] off);
        return RAM_AW'(slot * 32'(ROM_BYTES) + off);
    endfunction

endpackage

// ----- rtl/accc_ram.sv -----
module accc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/accc_cell.sv -----
module accc_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tok_init,
    input  accc_pkg::tok_ctl_t   tok_ctl,
    input  logic                 tok_in,
    output logic                 tok_out,
    input  accc_pkg::cfg_ctl_t   cfg_ctl,
    input  logic                 cfg_bit,
    output accc_pkg::slot_bits_t attr
);

    logic token_reg;
    logic token_next;
    accc_pkg::slot_bits_t attr_reg;
    accc_pkg::slot_bits_t attr_next;

    always_comb begin
        token_next = token_reg;
        if (tok_ctl.restart) begin
            token_next = tok_init;
        end else if (tok_ctl.advance) begin
            token_next = tok_in;
        end

        attr_next = attr_reg;
        if (cfg_ctl.we_en) begin
            attr_next.en = cfg_bit;
        end
        if (cfg_ctl.we_z3) begin
            attr_next.z3 = cfg_bit;
        end
        if (cfg_ctl.we_rom) begin
            attr_next.rom = cfg_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg <= tok_init;
            attr_reg  <= '0;
        end else begin
            token_reg <= token_next;
            attr_reg  <= attr_next;
        end
    end

    assign tok_out = token_reg;
    assign attr    = attr_reg;

endmodule

// ----- rtl/autoconfig_chain_controller_top.sv -----
// Sequence: restart and ROM load go from accept straight to the emit state; a config
//   write or a quiet read passes skip then emit, and a ROM read passes skip, read and emit;
//   skip steps past each disabled slot in turn (0..4 of them). One item in flight:
//   the next is accepted the cycle after the result is registered in the output.
// Reset (aresetn low, synchronous): token back to slot 0, masks cleared, handshakes idle;
//   ROM contents are not cleared and hold garbage until loaded.
module autoconfig_chain_controller_top (
    input  logic        aclk,
    input  logic        aresetn,

    // Config register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,

    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_bus_addr,
    input  logic [31:0] s_write_value,
    input  logic [1:0]  s_rom_slot,
    input  logic [6:0]  s_rom_offset,
    input  logic [7:0]  s_rom_byte,

    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_map_event,
    output logic        m_declined_event,
    output logic [2:0]  m_event_slot,
    output logic [31:0] m_assigned_base,
    output logic        m_chain_done
);

    localparam int NS = accc_pkg::NUM_SLOTS;
    localparam int PW = accc_pkg::POS_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    // Latched request word
    logic        is_write_reg;
    logic [31:0] off_reg;
    logic [31:0] wval_reg;

    // Staged result
    logic [7:0]  res_rd_reg,   res_rd_next;
    logic        res_map_reg,  res_map_next;
    logic        res_decl_reg, res_decl_next;
    logic [PW-1:0] res_slot_reg, res_slot_next;
    logic [31:0] res_base_reg, res_base_next;
    logic        res_done_reg, res_done_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_rd_reg;
    logic        out_map_reg;
    logic        out_decl_reg;
    logic [2:0]  out_slot_reg;
    logic [31:0] out_base_reg;
    logic        out_done_reg;

    // Chain of cells
    accc_pkg::tok_ctl_t   tok_ctl;
    accc_pkg::cfg_ctl_t   cfg_ctl;
    logic [NS:0]          tok_chain;
    logic [NS-1:0]        tok;
    logic [NS-1:0]        en_bits, z3_bits, rom_bits;
    accc_pkg::slot_bits_t cell_attr [NS];
    logic                 tok_end_reg, tok_end_next;

    logic          s_acc;
    logic          cfg_acc;
    logic [PW-1:0] pos;
    logic [31:0]   pos_wide;
    logic          done;
    logic          cur_en, cur_z3, cur_rom;
    logic          stop;
    logic          rom_hit;
    logic          map_hit, decl_hit;
    logic [15:0]   off16;
    logic          out_load;

    logic                        ram_we;
    logic [accc_pkg::RAM_AW-1:0] ram_waddr;
    logic [accc_pkg::RAM_AW-1:0] ram_raddr;
    logic [7:0]                  ram_rdata;

    assign s_acc   = s_valid && s_ready;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign s_ready = (state_reg == ST_IDLE);
    // The user must make config writes only land while idle; the block always takes them
    assign cfg_ready = 1'b1;

    // Decode register index into per-cell write strobes
    always_comb begin
        cfg_ctl = '0;
        if (cfg_acc) begin
            unique case (cfg_index)
                accc_pkg::CFG_ENABLED: cfg_ctl.we_en  = 1'b1;
                accc_pkg::CFG_ZORRO3:  cfg_ctl.we_z3  = 1'b1;
                accc_pkg::CFG_HAS_ROM: cfg_ctl.we_rom = 1'b1;
                default:               cfg_ctl = '0;
            endcase
        end
    end

    // Token enters at slot 0 only through restart/reset; cell i hands it to cell i+1
    assign tok_chain[0] = 1'b0;

    for (genvar i = 0; i < NS; i++) begin : g_cell
        logic cfg_bit;
        if (i < accc_pkg::MASK_BITS) begin : g_mask
            assign cfg_bit = cfg_data[i];
        end else begin : g_nomask
            // Slots past the mask width stay disabled, no Zorro III, no ROM
            assign cfg_bit = 1'b0;
        end

        accc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_init(i == 0),
            .tok_ctl (tok_ctl),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .cfg_ctl (cfg_ctl),
            .cfg_bit (cfg_bit),
            .attr    (cell_attr[i])
        );

        assign tok[i]      = tok_chain[i+1];
        assign en_bits[i]  = cell_attr[i].en;
        assign z3_bits[i]  = cell_attr[i].z3;
        assign rom_bits[i] = cell_attr[i].rom;
    end

    // End-of-chain marker: takes the token from the last cell
    always_comb begin
        tok_end_next = tok_end_reg;
        if (tok_ctl.restart) begin
            tok_end_next = 1'b0;
        end else if (tok_ctl.advance) begin
            tok_end_next = tok_chain[NS];
        end
    end

    // Encode token position
    always_comb begin
        pos = '0;
        for (int i = 0; i < NS; i++) begin
            if (tok[i]) begin
                pos = pos | PW'(i);
            end
        end
        if (tok_end_reg) begin
            pos = PW'(NS);
        end
    end

    assign pos_wide = 32'(pos);
    assign done     = tok_end_reg;
    assign cur_en   = |(tok & en_bits);
    assign cur_z3   = |(tok & z3_bits);
    assign cur_rom  = |(tok & rom_bits);
    assign stop     = done || cur_en;

    assign off16    = off_reg[15:0];
    assign rom_hit  = !done && cur_rom && (off_reg < 32'(accc_pkg::ROM_BYTES));
    assign map_hit  = !done && (cur_z3 ? (off16 == accc_pkg::Z3_HI_OFFSET)
                                       : (off16 == accc_pkg::BASE_HI_OFFSET));
    assign decl_hit = !done && !map_hit &&
                      ((off16 == accc_pkg::SHUTUP_OFFSET) ||
                       (off16 == accc_pkg::SHUTUP_ALT));

    // Token control: restart on an accepted restart, advance past disabled slots, advance on event
    always_comb begin
        tok_ctl.restart = s_acc && (s_action == accc_pkg::ACT_RESTART);
        tok_ctl.advance = 1'b0;
        if (state_reg == ST_SKIP) begin
            if (!stop) begin
                tok_ctl.advance = 1'b1;
            end else if (is_write_reg && (map_hit || decl_hit)) begin
                tok_ctl.advance = 1'b1;
            end
        end
    end

    // ROM store: load on an accepted load, read at current slot while skipping
    assign ram_we    = s_acc && (s_action == accc_pkg::ACT_LOAD) &&
                       (32'(s_rom_slot) < 32'(NS)) &&
                       (32'(s_rom_offset) < 32'(accc_pkg::ROM_BYTES));
    assign ram_waddr = accc_pkg::rom_addr(32'(s_rom_slot), 32'(s_rom_offset));
    assign ram_raddr = accc_pkg::rom_addr(pos_wide, off_reg);

    accc_ram #(
        .WIDTH(8),
        .DEPTH(accc_pkg::RAM_DEPTH)
    ) u_rom (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_rom_byte),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // Sequencer and staged result
    always_comb begin
        state_next    = state_reg;
        res_rd_next   = res_rd_reg;
        res_map_next  = res_map_reg;
        res_decl_next = res_decl_reg;
        res_slot_next = res_slot_reg;
        res_base_next = res_base_reg;
        res_done_next = res_done_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    // Quiet result by default; restart and load keep it
                    res_rd_next   = accc_pkg::QUIET_BYTE;
                    res_map_next  = 1'b0;
                    res_decl_next = 1'b0;
                    res_slot_next = '0;
                    res_base_next = '0;
                    res_done_next = 1'b0;
                    if ((s_action == accc_pkg::ACT_READ) ||
                        (s_action == accc_pkg::ACT_WRITE)) begin
                        state_next = ST_SKIP;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SKIP: begin
                if (stop) begin
                    res_slot_next = pos;
                    res_done_next = done;
                    if (is_write_reg) begin
                        res_map_next  = map_hit;
                        res_decl_next = decl_hit;
                        if (map_hit) begin
                            res_base_next = cur_z3 ? {wval_reg[15:0], 16'h0000}
                                                   : {8'h00, wval_reg[7:0], 16'h0000};
                        end
                        state_next = ST_EMIT;
                    end else if (rom_hit) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_READ: begin
                res_rd_next = ram_rdata;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tok_end_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tok_end_reg <= tok_end_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            is_write_reg <= (s_action == accc_pkg::ACT_WRITE);
            off_reg      <= s_bus_addr - accc_pkg::CONFIG_BASE;
            wval_reg     <= s_write_value;
        end
        res_rd_reg   <= res_rd_next;
        res_map_reg  <= res_map_next;
        res_decl_reg <= res_decl_next;
        res_slot_reg <= res_slot_next;
        res_base_reg <= res_base_next;
        res_done_reg <= res_done_next;
        if (out_load) begin
            out_rd_reg   <= res_rd_reg;
            out_map_reg  <= res_map_reg;
            out_decl_reg <= res_decl_reg;
            out_slot_reg <= 3'(32'(res_slot_reg));
            out_base_reg <= res_base_reg;
            out_done_reg <= res_done_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_read_data      = out_rd_reg;
    assign m_map_event      = out_map_reg;
    assign m_declined_event = out_decl_reg;
    assign m_event_slot     = out_slot_reg;
    assign m_assigned_base  = out_base_reg;
    assign m_chain_done     = out_done_reg;

    // Exactly one place in the chain holds the token
    a_token_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({tok, tok_end_reg}))
        else $error("chain token lost or duplicated");

    // A ROM read is only fetched right after the skip settles
    a_read_after_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> ($past(state_reg) == ST_SKIP))
        else $error("ROM fetch without a settled chain position");

    // Token never moves while the output is being loaded
    a_no_advance_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !tok_ctl.advance)
        else $error("chain advanced outside the skip phase");

    // A finished chain reports no events
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_chain_done) |-> (!m_map_event && !m_declined_event))
        else $error("event reported with no board left");

    // Map and decline are exclusive
    a_event_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_map_event && m_declined_event))
        else $error("board both mapped and declined");

endmodule
